### hdl/system_tick_timer_unit_assert.svh
// Assertion helpers shared by the timer RTL.
`ifndef SYSTEM_TICK_TIMER_UNIT_ASSERT_SVH
`define SYSTEM_TICK_TIMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sts_pkg.sv
package sts_pkg;

    localparam logic [31:0] MIN_DISTANCE = 32'd14;
    localparam logic [15:0] CPT_RESET    = 16'd327;

    localparam logic [1:0] OP_CYCLE = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_ELAP  = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_TICKLESS = 1'b0;
    localparam logic REG_CPT      = 1'b1;

    typedef logic [1:0] t_dsel;
    localparam t_dsel DSEL_DIFF = 2'd0;   // cycle_count - last_mark
    localparam t_dsel DSEL_ALL1 = 2'd1;   // all ones, for the tick limit
    localparam t_dsel DSEL_CC   = 2'd2;   // cycle_count, for its remainder

    typedef struct packed {
        logic  capture;
        logic  cyc_tl;
        logic  cyc_tk;
        logic  set_tk;
        logic  elap_tk;
        logic  div_start;
        t_dsel dsel;
        logic  ld_ticks;
        logic  mul;
        logic  adv_mark;
        logic  ld_max;
        logic  ld_rem;
        logic  clamp;
        logic  ld_cmp;
        logic  ld_elap;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       match;
        logic       div_busy;
        logic       div_done;
    } t_sts;

endpackage

### hdl/sts_div.sv
`include "system_tick_timer_unit_assert.svh"

module sts_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [15:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_divisor;

    logic [16:0] shifted;
    logic        ge;
    logic [16:0] diff;
    logic [15:0] n_rem;

    // one quotient bit per cycle, most significant first
    assign shifted = {r_rem, r_quo[31]};
    assign ge      = shifted >= {1'b0, r_divisor};
    assign diff    = shifted - {1'b0, r_divisor};
    assign n_rem   = ge ? diff[15:0] : shifted[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    `STS_ASSERT_IMP(a_rem_below_divisor, r_done, r_rem < r_divisor, "remainder not below divisor")
    `STS_ASSERT_NXT(a_busy_after_start, i_start && !r_busy, r_busy, "divider did not start")

endmodule

### hdl/sts_dp.sv
`include "system_tick_timer_unit_assert.svh"

module sts_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sts_pkg::t_cmd      i_cmd,
    output sts_pkg::t_sts      o_sts,
    input  logic [15:0]        i_cpt,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_req,
    input  logic               i_forever,
    output logic               o_ann_valid,
    output logic [31:0]        o_ann,
    output logic [31:0]        o_elap
);
    import sts_pkg::*;

    // timer state
    logic [31:0] r_cc;
    logic [31:0] r_cmp;
    logic [31:0] r_lm;
    logic [31:0] r_tc;
    logic [31:0] r_tt;
    logic [15:0] r_sub;

    // captured transaction and working values
    logic [1:0]         r_op;
    logic signed [31:0] r_req;
    logic               r_forever;
    logic [31:0]        r_ticks;
    logic [31:0]        r_prod;
    logic [31:0]        r_max;
    logic [15:0]        r_rem;
    logic               r_res_valid;
    logic [31:0]        r_res_ann;
    logic [31:0]        r_res_elap;
    logic               r_out_valid;
    logic [31:0]        r_out_ann;
    logic [31:0]        r_out_elap;

    logic [15:0]        cpt_eff;
    logic [16:0]        sub_inc;
    logic               tk_wrap;
    logic [31:0]        tc_inc;
    logic               tk_hit;
    logic [31:0]        dividend;
    logic               div_busy;
    logic               div_done;
    logic [31:0]        div_quo;
    logic [15:0]        div_rem;
    logic [47:0]        prod_full;
    logic [31:0]        cmp_dist;
    logic signed [33:0] req_ext;
    logic signed [33:0] req_dec;
    logic signed [33:0] max_ext;
    logic signed [33:0] req_clamp;
    logic [31:0]        ticks_up;

    assign cpt_eff = (i_cpt == 16'd0) ? 16'd1 : i_cpt;
    assign sub_inc = {1'b0, r_sub} + 17'd1;
    assign tk_wrap = sub_inc >= {1'b0, cpt_eff};
    assign tc_inc  = r_tc + 32'd1;
    assign tk_hit  = tk_wrap && (tc_inc == r_tt);

    always_comb begin
        case (i_cmd.dsel)
            DSEL_DIFF: dividend = r_cc - r_lm;
            DSEL_ALL1: dividend = '1;
            DSEL_CC:   dividend = r_cc;
            default:   dividend = r_cc - r_lm;
        endcase
    end

    sts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (cpt_eff),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign prod_full = r_ticks * cpt_eff;

    // push the compare out by one tick when it lands too close
    assign cmp_dist = (r_prod < MIN_DISTANCE) ? r_prod + {16'd0, cpt_eff} : r_prod;

    // clamp request - 1 into [0, max], then round up past a partial tick
    assign req_ext   = r_forever ? signed'({2'b00, r_max}) : 34'(r_req);
    assign req_dec   = req_ext - 34'sd1;
    assign max_ext   = signed'({2'b00, r_max});
    assign req_clamp = (req_dec > max_ext) ? max_ext :
                       ((req_dec < 34'sd0) ? 34'sd0 : req_dec);
    assign ticks_up  = req_clamp[31:0] + {31'd0, (r_rem != 16'd0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc  <= '0;
            r_cmp <= '0;
            r_lm  <= '0;
            r_tc  <= '0;
            r_tt  <= '0;
            r_sub <= '0;
        end else begin
            if (i_cmd.cyc_tl) begin
                r_cc <= r_cc + 32'd1;
            end
            if (i_cmd.cyc_tk) begin
                if (tk_wrap) begin
                    r_sub <= '0;
                    r_tc  <= tc_inc;
                    if (tk_hit) begin
                        r_lm <= tc_inc;
                    end
                end else begin
                    r_sub <= sub_inc[15:0];
                end
            end
            if (i_cmd.set_tk) begin
                if (r_forever) begin
                    r_tt <= r_tc;
                end else if (r_req < 32'sd1) begin
                    r_tt <= r_tc + 32'd1;
                end else begin
                    r_tt <= r_tc + unsigned'(r_req);
                end
            end
            if (i_cmd.adv_mark) begin
                r_lm <= r_lm + r_prod;
            end
            if (i_cmd.ld_cmp) begin
                r_cmp <= r_cc + cmp_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_req       <= i_req;
            r_forever   <= i_forever;
            r_res_valid <= 1'b0;
            r_res_ann   <= '0;
            r_res_elap  <= '0;
        end
        if (i_cmd.cyc_tk && tk_hit) begin
            r_res_valid <= 1'b1;
            r_res_ann   <= tc_inc - r_lm;
        end
        if (i_cmd.elap_tk) begin
            r_res_elap <= r_tc - r_lm;
        end
        if (i_cmd.ld_ticks) begin
            r_ticks     <= div_quo;
            r_res_valid <= 1'b1;
            r_res_ann   <= div_quo;
        end
        if (i_cmd.ld_elap) begin
            r_res_elap <= div_quo;
        end
        if (i_cmd.ld_max) begin
            r_max <= div_quo - 32'd2;
        end
        if (i_cmd.ld_rem) begin
            r_rem <= div_rem;
        end
        if (i_cmd.clamp) begin
            r_ticks <= ticks_up;
        end
        if (i_cmd.mul) begin
            r_prod <= prod_full[31:0];
        end
        if (i_cmd.load_out) begin
            r_out_valid <= r_res_valid;
            r_out_ann   <= r_res_ann;
            r_out_elap  <= r_res_elap;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.match    = (r_cc == r_cmp);
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;

    assign o_ann_valid = r_out_valid;
    assign o_ann       = r_out_ann;
    assign o_elap      = r_out_elap;

    `STS_ASSERT_NXT(a_sub_below_cpt, i_cmd.cyc_tk, r_sub < $past(cpt_eff), "subtick not below cycles per tick")

endmodule

### hdl/sts_ctrl.sv
`include "system_tick_timer_unit_assert.svh"

module sts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tickless,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sts_pkg::t_sts i_sts,
    output sts_pkg::t_cmd o_cmd
);
    import sts_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_CHK       = 4'd2;
    localparam logic [3:0] S_WAIT_ANN  = 4'd3;
    localparam logic [3:0] S_MUL_ANN   = 4'd4;
    localparam logic [3:0] S_ADV       = 4'd5;
    localparam logic [3:0] S_WAIT_MAX  = 4'd6;
    localparam logic [3:0] S_WAIT_REM  = 4'd7;
    localparam logic [3:0] S_CLAMP     = 4'd8;
    localparam logic [3:0] S_MUL_TO    = 4'd9;
    localparam logic [3:0] S_CMP       = 4'd10;
    localparam logic [3:0] S_WAIT_ELAP = 4'd11;
    localparam logic [3:0] S_FINISH    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.dsel = DSEL_DIFF;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_sts.op)
                    OP_CYCLE: begin
                        if (i_tickless) begin
                            o_cmd.cyc_tl = 1'b1;
                            n_state      = S_CHK;
                        end else begin
                            o_cmd.cyc_tk = 1'b1;
                        end
                    end
                    OP_SET: begin
                        if (i_tickless) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.dsel      = DSEL_ALL1;
                            n_state         = S_WAIT_MAX;
                        end else begin
                            o_cmd.set_tk = 1'b1;
                        end
                    end
                    OP_ELAP: begin
                        if (i_tickless) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.dsel      = DSEL_DIFF;
                            n_state         = S_WAIT_ELAP;
                        end else begin
                            o_cmd.elap_tk = 1'b1;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_CHK: begin
                if (i_sts.match) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.dsel      = DSEL_DIFF;
                    n_state         = S_WAIT_ANN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_WAIT_ANN: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_ticks = 1'b1;
                    n_state        = S_MUL_ANN;
                end
            end
            S_MUL_ANN: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv_mark = 1'b1;
                n_state        = S_FINISH;
            end
            S_WAIT_MAX: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_max    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.dsel      = DSEL_CC;
                    n_state         = S_WAIT_REM;
                end
            end
            S_WAIT_REM: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_rem = 1'b1;
                    n_state      = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MUL_TO;
            end
            S_MUL_TO: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.ld_cmp = 1'b1;
                n_state      = S_FINISH;
            end
            S_WAIT_ELAP: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_elap = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `STS_ASSERT_IMP(a_div_idle_at_start, o_cmd.div_start, !i_sts.div_busy, "divider restarted while busy")
    `STS_ASSERT_NXT(a_accept_to_decode, i_in_valid && o_in_ready, r_state == S_DECODE, "accepted transaction not decoded")

endmodule

### hdl/system_tick_timer_unit.sv
// Kernel tick timer with a tickless compare mode and a periodic ticking mode. Each input
// transaction is one RTC cycle, a set-timeout request or an elapsed-ticks read, and yields one
// result transaction. Items are handled one at a time; ticking-mode items and a tickless RTC
// cycle without a compare match do not use the divider. The rest wait on one shared restoring
// divider that retires one quotient bit per cycle: a tickless elapsed read and a compare match
// each divide once, and a tickless set-timeout divides twice. A new transaction is taken while
// the previous result still waits in the output register.
module system_tick_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // timeout_ticks[31:0], wait_forever[32], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // announce_ticks[31:0], elapsed_ticks[63:32]
    output logic [0:0]  m_axis_tuser,   // announce_valid[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sts_pkg::*;

    logic        r_tickless;
    logic [15:0] r_cpt;
    logic        cfg_wr;
    t_cmd        cmd;
    t_sts        sts;
    logic        ann_valid;
    logic [31:0] ann;
    logic [31:0] elap;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tickless <= 1'b1;
            r_cpt      <= CPT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CPT) begin
                r_cpt <= pwdata[15:0];
            end else begin
                r_tickless <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TICKLESS) ? {31'd0, r_tickless} : {16'd0, r_cpt};

    sts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tickless  (r_tickless),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cpt       (r_cpt),
        .i_op        (s_axis_tuser),
        .i_req       ($signed(s_axis_tdata[31:0])),
        .i_forever   (s_axis_tdata[32]),
        .o_ann_valid (ann_valid),
        .o_ann       (ann),
        .o_elap      (elap)
    );

    assign m_axis_tdata = {elap, ann};
    assign m_axis_tuser = ann_valid;

endmodule
